@@ rtl/core/ftts_pkg.sv @@
// Shared types and constants of the frequency table target select block.
package ftts_pkg;

  localparam int TableDepth = 16;
  localparam int SlotW      = $clog2(TableDepth);
  localparam int FreqW      = 32;
  localparam int CountW     = 5;
  localparam int AddrW      = 4;
  localparam int DataW      = 32;

  localparam logic [FreqW-1:0] FreqAllOnes = '1;

  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_QUERY  = 2'd1,
    MODE_BOUNDS = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_QUERY  = 2'd1,
    OP_BOUNDS = 2'd2,
    OP_FAIL   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_FLOOR   = 2'd0,
    REG_CEILING = 2'd1,
    REG_COUNT   = 2'd2,
    REG_ONLINE  = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [SlotW-1:0] slot;
    logic [FreqW-1:0] freq;
    logic             valid;
    logic [FreqW-1:0] target;
    logic             rel_h;
  } cmd_t;

  typedef struct packed {
    logic [FreqW-1:0]  floor_freq;
    logic [FreqW-1:0]  ceil_freq;
    logic [CountW-1:0] used;
  } scan_cfg_t;

endpackage

@@ rtl/core/ftts_front.sv @@
// Front end: classifies an accepted word into a command for the back end.
module ftts_front (
  input  logic [1:0]                  mode_i,
  input  logic [ftts_pkg::SlotW-1:0]  entry_slot_i,
  input  logic [ftts_pkg::FreqW-1:0]  entry_frequency_i,
  input  logic                        entry_valid_i,
  input  logic [ftts_pkg::FreqW-1:0]  target_frequency_i,
  input  logic                        relation_i,
  input  logic                        online_i,
  output ftts_pkg::cmd_t              cmd_o
);

  ftts_pkg::op_e op;

  always_comb begin
    unique case (ftts_pkg::mode_e'(mode_i))
      ftts_pkg::MODE_WRITE:  op = ftts_pkg::OP_WRITE;
      ftts_pkg::MODE_QUERY:  op = online_i ? ftts_pkg::OP_QUERY : ftts_pkg::OP_FAIL;
      ftts_pkg::MODE_BOUNDS: op = ftts_pkg::OP_BOUNDS;
      default:               op = ftts_pkg::OP_FAIL;
    endcase
  end

  assign cmd_o.op     = op;
  assign cmd_o.slot   = entry_slot_i;
  assign cmd_o.freq   = entry_frequency_i;
  assign cmd_o.valid  = entry_valid_i;
  assign cmd_o.target = target_frequency_i;
  assign cmd_o.rel_h  = relation_i;

endmodule

@@ rtl/core/ftts_queue.sv @@
// Two-entry command queue between the front end and the back end.
module ftts_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ftts_pkg::cmd_t push_cmd_i,
  input  logic           pop_i,
  output ftts_pkg::cmd_t pop_cmd_o,
  output logic           empty_o,
  output logic           full_o
);

  ftts_pkg::cmd_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     fill_q, fill_d;

  assign empty_o   = (fill_q == 2'd0);
  assign full_o    = (fill_q == 2'd2);
  assign pop_cmd_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ rtl/core/ftts_back.sv @@
// Back end: holds the frequency table and scans it one entry per cycle.
module ftts_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        avail_i,
  input  ftts_pkg::cmd_t              cmd_i,
  input  ftts_pkg::scan_cfg_t         cfg_i,
  output logic                        pop_o,
  output logic                        done_o,
  output logic                        status_o,
  output logic [ftts_pkg::SlotW-1:0]  chosen_slot_o,
  output logic [ftts_pkg::FreqW-1:0]  min_frequency_o,
  output logic [ftts_pkg::FreqW-1:0]  max_frequency_o
);

  logic [ftts_pkg::FreqW-1:0] table_q [ftts_pkg::TableDepth];
  logic                       valid_q [ftts_pkg::TableDepth];

  ftts_pkg::state_e           state_q, state_d;
  ftts_pkg::cmd_t             cur_q, cur_d;
  logic [ftts_pkg::CountW-1:0] idx_q, idx_d;
  logic                       best_ok_q, best_ok_d, alt_ok_q, alt_ok_d;
  logic [ftts_pkg::FreqW-1:0] best_f_q, best_f_d, alt_f_q, alt_f_d;
  logic [ftts_pkg::SlotW-1:0] best_i_q, best_i_d, alt_i_q, alt_i_d;

  logic                       done_q, done_d, status_q, status_d;
  logic [ftts_pkg::SlotW-1:0] slot_q, slot_d;
  logic [ftts_pkg::FreqW-1:0] min_q, min_d, max_q, max_d;

  logic [ftts_pkg::SlotW-1:0] rd_idx;
  logic [ftts_pkg::FreqW-1:0] f;
  logic                       v, in_range, is_query, cand, on_side;
  logic                       to_best, to_alt, best_take, alt_take, table_we;

  assign rd_idx   = idx_q[ftts_pkg::SlotW-1:0];
  assign f        = table_q[rd_idx];
  assign v        = valid_q[rd_idx];
  assign in_range = (f >= cfg_i.floor_freq) && (f <= cfg_i.ceil_freq);
  assign is_query = (cur_q.op == ftts_pkg::OP_QUERY);
  assign cand     = v && (in_range || !is_query);
  assign on_side  = cur_q.rel_h ? (f <= cur_q.target) : (f >= cur_q.target);
  assign to_best  = cand && (on_side || !is_query);
  assign to_alt   = cand && (!on_side || !is_query);

  // In a bounds scan the best slot tracks the minimum and the alternate the maximum.
  assign best_take = !best_ok_q ||
                     ((is_query && cur_q.rel_h) ? (f >= best_f_q) : (f <= best_f_q));
  assign alt_take  = !alt_ok_q ||
                     ((is_query && cur_q.rel_h) ? (f <= alt_f_q) : (f >= alt_f_q));

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    idx_d     = idx_q;
    best_ok_d = best_ok_q;
    best_f_d  = best_f_q;
    best_i_d  = best_i_q;
    alt_ok_d  = alt_ok_q;
    alt_f_d   = alt_f_q;
    alt_i_d   = alt_i_q;
    done_d    = 1'b0;
    status_d  = status_q;
    slot_d    = slot_q;
    min_d     = min_q;
    max_d     = max_q;
    pop_o     = 1'b0;
    table_we  = 1'b0;

    unique case (state_q)
      ftts_pkg::ST_IDLE: begin
        if (avail_i) begin
          pop_o     = 1'b1;
          cur_d     = cmd_i;
          idx_d     = '0;
          best_ok_d = 1'b0;
          alt_ok_d  = 1'b0;
          unique case (cmd_i.op)
            ftts_pkg::OP_WRITE: begin
              table_we = 1'b1;
              done_d   = 1'b1;
              status_d = 1'b0;
              slot_d   = '0;
              min_d    = '0;
              max_d    = '0;
            end
            ftts_pkg::OP_FAIL: begin
              done_d   = 1'b1;
              status_d = 1'b1;
              slot_d   = '0;
              min_d    = '0;
              max_d    = '0;
            end
            default: begin
              state_d = ftts_pkg::ST_SCAN;
            end
          endcase
        end
      end
      ftts_pkg::ST_SCAN: begin
        if (idx_q == cfg_i.used) begin
          state_d  = ftts_pkg::ST_IDLE;
          done_d   = 1'b1;
          slot_d   = '0;
          min_d    = '0;
          max_d    = '0;
          status_d = !(best_ok_q || alt_ok_q);
          if (is_query) begin
            if (best_ok_q) begin
              slot_d = best_i_q;
            end else if (alt_ok_q) begin
              slot_d = alt_i_q;
            end
          end else if (best_ok_q) begin
            min_d = best_f_q;
            max_d = alt_f_q;
          end
        end else begin
          idx_d = idx_q + ftts_pkg::CountW'(1);
          if (to_best && best_take) begin
            best_ok_d = 1'b1;
            best_f_d  = f;
            best_i_d  = rd_idx;
          end
          if (to_alt && alt_take) begin
            alt_ok_d = 1'b1;
            alt_f_d  = f;
            alt_i_d  = rd_idx;
          end
        end
      end
      default: begin
        state_d = ftts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ftts_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    idx_q     <= idx_d;
    best_ok_q <= best_ok_d;
    best_f_q  <= best_f_d;
    best_i_q  <= best_i_d;
    alt_ok_q  <= alt_ok_d;
    alt_f_q   <= alt_f_d;
    alt_i_q   <= alt_i_d;
    status_q  <= status_d;
    slot_q    <= slot_d;
    min_q     <= min_d;
    max_q     <= max_d;
  end

  always_ff @(posedge clk_i) begin
    if (table_we) begin
      table_q[cmd_i.slot] <= cmd_i.freq;
      valid_q[cmd_i.slot] <= cmd_i.valid;
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign chosen_slot_o   = slot_q;
  assign min_frequency_o = min_q;
  assign max_frequency_o = max_q;

endmodule

@@ rtl/core/frequency_table_target_select_top.sv @@
// Top level of the frequency table target select block with its register port.
//
// A word is taken when start is high and busy is low; busy rises only when the
// two-entry command queue is full. Every word gives exactly one result word,
// shown for one cycle with done_o high; the receiver cannot stall it. A table
// write or a failing word is answered from the idle state; a target query or a
// bounds word scans the first entry_count table entries (at most 16), as the
// back end reads one table entry per cycle. Words are carried out in order of
// arrival.
module frequency_table_target_select_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ftts_pkg::AddrW-1:0]  paddr,
  input  logic [ftts_pkg::DataW-1:0]  pwdata,
  output logic [ftts_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  mode_i,
  input  logic [ftts_pkg::SlotW-1:0]  entry_slot_i,
  input  logic [ftts_pkg::FreqW-1:0]  entry_frequency_i,
  input  logic                        entry_valid_i,
  input  logic [ftts_pkg::FreqW-1:0]  target_frequency_i,
  input  logic                        relation_i,
  output logic                        done_o,
  output logic                        status_o,
  output logic [ftts_pkg::SlotW-1:0]  chosen_slot_o,
  output logic [ftts_pkg::FreqW-1:0]  min_frequency_o,
  output logic [ftts_pkg::FreqW-1:0]  max_frequency_o
);

  logic [ftts_pkg::FreqW-1:0]  floor_q, ceil_q;
  logic [ftts_pkg::CountW-1:0] count_q;
  logic                        online_q;
  logic                        cfg_we;
  ftts_pkg::reg_e              reg_sel;

  ftts_pkg::cmd_t              front_cmd, back_cmd;
  ftts_pkg::scan_cfg_t         scan_cfg;
  logic                        push, pop, q_empty, q_full;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_sel = ftts_pkg::reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q  <= '0;
      ceil_q   <= ftts_pkg::FreqAllOnes;
      count_q  <= '0;
      online_q <= 1'b1;
    end else if (cfg_we) begin
      unique case (reg_sel)
        ftts_pkg::REG_FLOOR:   floor_q  <= pwdata;
        ftts_pkg::REG_CEILING: ceil_q   <= pwdata;
        ftts_pkg::REG_COUNT:   count_q  <= pwdata[ftts_pkg::CountW-1:0];
        ftts_pkg::REG_ONLINE:  online_q <= pwdata[0];
        default:               online_q <= online_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ftts_pkg::REG_FLOOR:   prdata = floor_q;
      ftts_pkg::REG_CEILING: prdata = ceil_q;
      ftts_pkg::REG_COUNT:   prdata = {{(ftts_pkg::DataW-ftts_pkg::CountW){1'b0}}, count_q};
      ftts_pkg::REG_ONLINE:  prdata = {{(ftts_pkg::DataW-1){1'b0}}, online_q};
      default:               prdata = '0;
    endcase
  end

  assign scan_cfg.floor_freq = floor_q;
  assign scan_cfg.ceil_freq  = ceil_q;
  assign scan_cfg.used       = (count_q > ftts_pkg::CountW'(ftts_pkg::TableDepth))
                             ? ftts_pkg::CountW'(ftts_pkg::TableDepth) : count_q;

  assign busy = q_full;
  assign push = start && !q_full;

  ftts_front u_front (
    .mode_i             (mode_i),
    .entry_slot_i       (entry_slot_i),
    .entry_frequency_i  (entry_frequency_i),
    .entry_valid_i      (entry_valid_i),
    .target_frequency_i (target_frequency_i),
    .relation_i         (relation_i),
    .online_i           (online_q),
    .cmd_o              (front_cmd)
  );

  ftts_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (front_cmd),
    .pop_i      (pop),
    .pop_cmd_o  (back_cmd),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  ftts_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .avail_i         (!q_empty),
    .cmd_i           (back_cmd),
    .cfg_i           (scan_cfg),
    .pop_o           (pop),
    .done_o          (done_o),
    .status_o        (status_o),
    .chosen_slot_o   (chosen_slot_o),
    .min_frequency_o (min_frequency_o),
    .max_frequency_o (max_frequency_o)
  );

endmodule
